FILE: design/tmie_pkg.sv
// Shared types and constants of the tape machine instruction executor.
package tmie_pkg;

  // Tape geometry.
  localparam int unsigned TapeDepth = 65536;
  localparam int unsigned AddrW     = (TapeDepth > 1) ? $clog2(TapeDepth) : 1;
  localparam int unsigned FillW     = AddrW + 1;
  localparam int unsigned CellW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ActW      = 4;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TapeDepth - 1);

  // Instruction codes.
  typedef enum logic [ActW-1:0] {
    ActNop     = 4'd0,
    ActHalt    = 4'd1,
    ActHaltOne = 4'd2,
    ActInc     = 4'd3,
    ActDec     = 4'd4,
    ActRight   = 4'd5,
    ActClear   = 4'd6,
    ActDouble  = 4'd7,
    ActLeft    = 4'd8,
    ActOut     = 4'd9,
    ActOpen    = 4'd10,
    ActClose   = 4'd11,
    ActRead    = 4'd12,
    ActHome    = 4'd13
  } action_e;

  // One result word.
  typedef struct packed {
    logic             take_jump;
    logic             out_valid;
    logic [ByteW-1:0] out_char;
    logic             halt;
  } result_t;

  // Cell update requested by the execute logic.
  typedef struct packed {
    logic             wr;
    logic [CellW-1:0] data;
  } cell_upd_t;

endpackage

FILE: design/tmie_if.sv
// Handshake channels for instruction words and result words.
interface tmie_in_if import tmie_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] input_byte;
  logic             input_ended;

  modport source (output valid, output action, output input_byte, output input_ended,
                  input ready);
  modport sink   (input valid, input action, input input_byte, input input_ended,
                  output ready);
endinterface

interface tmie_out_if import tmie_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             take_jump;
  logic             out_valid;
  logic [ByteW-1:0] out_char;
  logic             halt;

  modport source (output valid, output take_jump, output out_valid, output out_char,
                  output halt, input ready);
  modport sink   (input valid, input take_jump, input out_valid, input out_char,
                  input halt, output ready);
endinterface

FILE: design/tmie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tmie_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tmie_alu.sv
// Instruction decode and cell arithmetic for one executing instruction.
module tmie_alu import tmie_pkg::*; (
  input  logic [ActW-1:0]  action_i,
  input  logic [CellW-1:0] cell_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             ended_i,
  output cell_upd_t        upd_o,
  output result_t          res_o
);

  // Compute the new cell value and the result word.
  always_comb begin
    upd_o = '0;
    res_o = '0;
    case (action_i)
      ActHalt: begin
        res_o.halt = 1'b1;
      end
      ActHaltOne: begin
        res_o.halt = (cell_i == CellW'(1));
      end
      ActInc: begin
        upd_o.wr   = 1'b1;
        upd_o.data = cell_i + CellW'(1);
      end
      ActDec: begin
        upd_o.wr   = 1'b1;
        upd_o.data = cell_i - CellW'(1);
      end
      ActClear: begin
        upd_o.wr   = 1'b1;
        upd_o.data = '0;
      end
      ActDouble: begin
        upd_o.wr   = 1'b1;
        upd_o.data = {cell_i[CellW-2:0], 1'b0};
      end
      ActOut: begin
        res_o.out_valid = 1'b1;
        res_o.out_char  = cell_i[ByteW-1:0];
      end
      ActOpen: begin
        res_o.take_jump = (cell_i == '0);
      end
      ActClose: begin
        res_o.take_jump = (cell_i != '0);
      end
      ActRead: begin
        upd_o.wr   = 1'b1;
        upd_o.data = ended_i ? {CellW{1'b1}} : {{(CellW-ByteW){1'b0}}, byte_i};
      end
      default: begin
        // Nop, pointer moves and unused codes leave the cell alone.
      end
    endcase
  end

endmodule

FILE: design/tape_machine_instruction_executor.sv
// Top level of the tape machine instruction executor.
// Each accepted word passes through the execute stage register and then the output register.
// Throughput: one word per cycle unless the output stalls, set by the single read and write
// port of the tape RAM, with the executing word's write forwarded to the word read behind it.
// Reset clears the cell pointer and the fill count; there is no clearing pass, cells at or
// above the fill count read as zero, and words are accepted as soon as reset is released.
module tape_machine_instruction_executor import tmie_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tmie_in_if.sink    in_i,
  tmie_out_if.source out_o
);

  // Word held in the execute stage.
  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] input_byte;
    logic             input_ended;
    logic [AddrW-1:0] addr;
    logic             cell_ok;
  } exec_t;

  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             s1_valid_q;
  exec_t            s1_q;
  logic             out_valid_q;
  result_t          out_res_q;
  logic             fwd_we_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [CellW-1:0] fwd_data_q;

  logic             accept;
  logic             s1_adv;
  logic [CellW-1:0] rdata;
  logic [CellW-1:0] cur_cell;
  cell_upd_t        upd;
  result_t          res;
  logic             at_fill;
  logic             ram_we;
  logic [CellW-1:0] ram_wdata;

  // Handshake: the execute stage moves on when the output register is free or drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  // Pointer update happens at accept, since it does not depend on the cell value.
  always_comb begin
    ptr_d = ptr_q;
    case (in_i.action)
      ActRight: begin
        if (ptr_q != LastAddr) begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      ActLeft: begin
        if (ptr_q != '0) begin
          ptr_d = ptr_q - AddrW'(1);
        end
      end
      ActHome: begin
        ptr_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Current cell: forwarded write first, then RAM data if the cell was ever written.
  always_comb begin
    if (fwd_we_q && (fwd_addr_q == s1_q.addr)) begin
      cur_cell = fwd_data_q;
    end else if (s1_q.cell_ok) begin
      cur_cell = rdata;
    end else begin
      cur_cell = '0;
    end
  end

  tmie_alu u_alu (
    .action_i (s1_q.action),
    .cell_i   (cur_cell),
    .byte_i   (s1_q.input_byte),
    .ended_i  (s1_q.input_ended),
    .upd_o    (upd),
    .res_o    (res)
  );

  // A move right off the fill boundary writes a zero there so the fill count can grow.
  assign at_fill   = ({1'b0, s1_q.addr} == fill_q);
  assign ram_we    = s1_adv && (upd.wr || ((s1_q.action == ActRight) && at_fill));
  assign ram_wdata = upd.wr ? upd.data : '0;

  always_comb begin
    fill_d = fill_q;
    if (ram_we && at_fill) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  tmie_ram #(
    .Width (CellW),
    .Depth (TapeDepth)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_we_q    <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        ptr_q    <= ptr_d;
        fwd_we_q <= ram_we;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.action      <= in_i.action;
      s1_q.input_byte  <= in_i.input_byte;
      s1_q.input_ended <= in_i.input_ended;
      s1_q.addr        <= ptr_q;
      s1_q.cell_ok     <= ({1'b0, ptr_q} < fill_q);
      fwd_addr_q       <= s1_q.addr;
      fwd_data_q       <= ram_wdata;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  // Result word.
  assign out_o.valid     = out_valid_q;
  assign out_o.take_jump = out_res_q.take_jump;
  assign out_o.out_valid = out_res_q.out_valid;
  assign out_o.out_char  = out_res_q.out_char;
  assign out_o.halt      = out_res_q.halt;

endmodule

FILE: tb/sv/tape_machine_instruction_executor_tb.sv
// Self-checking testbench for the tape machine instruction executor.
module tape_machine_instruction_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmie_pkg::*;

  // Action codes that the block treats as no-ops.
  localparam logic [ActW-1:0] ActSpare0 = 4'd14;
  localparam logic [ActW-1:0] ActSpare1 = 4'd15;

  logic clk_i;
  logic rst_ni;

  tmie_in_if  in_if ();
  tmie_out_if out_if ();

  tape_machine_instruction_executor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the tape and head; unwritten cells read as zero.
  logic [CellW-1:0] tape_mirror [logic [AddrW-1:0]];
  logic [AddrW-1:0] head_ptr;

  // Results predicted for accepted words, oldest first.
  result_t pending_results [$];
  int unsigned fail_count;

  // Sender pacing: words left in the current burst.
  int unsigned burst_left;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Apply one instruction to the shadow tape and return its result word.
  function automatic result_t execute_on_tape(logic [ActW-1:0] act, logic [ByteW-1:0] byte_in,
                                              logic ended);
    result_t res;
    logic [CellW-1:0] cur;
    res = '0;
    cur = tape_mirror.exists(head_ptr) ? tape_mirror[head_ptr] : '0;
    case (act)
      ActHalt:    res.halt = 1'b1;
      ActHaltOne: res.halt = (cur == CellW'(1));
      ActInc:     tape_mirror[head_ptr] = cur + 1'b1;
      ActDec:     tape_mirror[head_ptr] = cur - 1'b1;
      ActRight: begin
        if (head_ptr != LastAddr) head_ptr = head_ptr + 1'b1;
      end
      ActClear:   tape_mirror[head_ptr] = '0;
      ActDouble:  tape_mirror[head_ptr] = {cur[CellW-2:0], 1'b0};
      ActLeft: begin
        if (head_ptr != '0) head_ptr = head_ptr - 1'b1;
      end
      ActOut: begin
        res.out_valid = 1'b1;
        res.out_char  = cur[ByteW-1:0];
      end
      ActOpen:    res.take_jump = (cur == '0);
      ActClose:   res.take_jump = (cur != '0);
      ActRead:    tape_mirror[head_ptr] = ended ? {CellW{1'b1}} : CellW'(byte_in);
      ActHome:    head_ptr = '0;
      default: ;
    endcase
    return res;
  endfunction

  // Offer one word, wait for it to be taken, then record its prediction.
  task automatic send_word(logic [ActW-1:0] act, logic [ByteW-1:0] byte_in = '0,
                           logic ended = 1'b0);
    int unsigned gap;
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.input_byte  <= byte_in;
    in_if.input_ended <= ended;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(execute_on_tape(act, byte_in, ended));
    // End of a burst: drop valid for a random gap and pick the next burst length.
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Every operation, wrap of the cell arithmetic, end of input and the spare codes.
  task automatic test_each_operation();
    send_word(ActNop);
    send_word(ActOut);
    send_word(ActOpen);
    send_word(ActClose);
    send_word(ActHaltOne);
    send_word(ActDec);                  // zero wraps to all ones
    send_word(ActOut);
    send_word(ActDouble);               // top bit falls off
    send_word(ActClose);
    send_word(ActOpen);
    send_word(ActInc);
    send_word(ActInc);                  // all ones wraps to zero
    send_word(ActInc);
    send_word(ActHaltOne);
    send_word(ActHalt);
    send_word(ActRead, 8'hFF, 1'b0);
    send_word(ActRead, 8'h3C, 1'b1);    // end of input overrides the byte
    send_word(ActLeft);                 // already at the first cell
    send_word(ActRight);
    send_word(ActRead, 8'h00, 1'b0);
    send_word(ActLeft);
    send_word(ActOut);
    send_word(ActRight);
    send_word(ActHome);
    send_word(ActSpare0, 8'hA5, 1'b1);
    send_word(ActSpare1, 8'h5A, 1'b0);
    send_word(ActClear);
    send_word(ActOut);
  endtask

  // Walk the head out to a far cell, use cells there, then bring it home.
  task automatic test_head_limits();
    send_word(ActHome);
    repeat (48) send_word(ActRight);
    send_word(ActRead, 8'h81, 1'b0);
    send_word(ActInc);
    send_word(ActOut);
    send_word(ActLeft);
    send_word(ActOut);
    send_word(ActDec);
    send_word(ActRight);
    send_word(ActClose);
    send_word(ActDouble);
    send_word(ActOut);
    send_word(ActHome);
    send_word(ActOut);
  endtask

  // Random instruction streams mixed with count-down loops.
  task automatic test_random_programs(int unsigned n_words);
    int unsigned done_words;
    int unsigned sel;
    int unsigned loops;
    logic [ActW-1:0] act;
    done_words = 0;
    while (done_words < n_words) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // Count-down loop: load a small value, then decrement and test it each pass.
        loops = $urandom_range(0, 6);
        send_word(ActRead, ByteW'(loops), 1'b0);
        send_word(ActOpen);
        repeat (loops) begin
          send_word(ActHaltOne);
          send_word(ActDec);
          send_word(ActClose);
        end
        done_words += 2 + 3 * loops;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 18)      act = ActInc;
        else if (sel < 30) act = ActDec;
        else if (sel < 42) act = ActRight;
        else if (sel < 54) act = ActLeft;
        else if (sel < 62) act = ActOut;
        else if (sel < 68) act = ActOpen;
        else if (sel < 74) act = ActClose;
        else if (sel < 82) act = ActRead;
        else if (sel < 86) act = ActClear;
        else if (sel < 90) act = ActDouble;
        else if (sel < 94) act = ActHaltOne;
        else if (sel < 96) act = ActHalt;
        else if (sel < 98) act = ActHome;
        else begin
          sel = $urandom_range(0, 2);
          act = (sel == 0) ? ActNop : ((sel == 1) ? ActSpare0 : ActSpare1);
        end
        send_word(act, ByteW'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        if (act != ActNop && act != ActSpare0 && act != ActSpare1) done_words++;
      end
    end
  endtask

  // Receiver: ready runs of random length broken by short stalls.
  initial begin
    int unsigned run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b1;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling) run_left = $urandom_range(1, 6);
        else run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
      end
      run_left--;
      out_if.ready <= !stalling;
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no prediction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.take_jump !== want.take_jump) begin
          $error("take_jump: expected %0b, got %0b", want.take_jump, out_if.take_jump);
          fail_count++;
        end
        if (out_if.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0b, got %0b", want.out_valid, out_if.out_valid);
          fail_count++;
        end
        if (out_if.out_char !== want.out_char) begin
          $error("out_char: expected %02h, got %02h", want.out_char, out_if.out_char);
          fail_count++;
        end
        if (out_if.halt !== want.halt) begin
          $error("halt: expected %0b, got %0b", want.halt, out_if.halt);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    fail_count = 0;
    head_ptr = '0;
    burst_left = 4;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ActNop;
    in_if.input_byte  <= '0;
    in_if.input_ended <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_each_operation();
    test_random_programs(915);
    test_head_limits();
    test_random_programs(915);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
